// ----- rtl/triangle_tangent_bitangent_macros.svh -----
// Assertion macros shared by the tangent-space block.
`ifndef TRIANGLE_TANGENT_BITANGENT_MACROS_SVH
`define TRIANGLE_TANGENT_BITANGENT_MACROS_SVH
// Assert that antecedent implies consequent in the same cycle.
`define TTB_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Assert that antecedent implies consequent in the next cycle.
`define TTB_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

// ----- rtl/ttb_pkg.sv -----
// Shared constants and types for the tangent-space block.
package ttb_pkg;
    localparam int WORD_WIDTH = 32;
    localparam int FRAC_BITS  = 16;
    localparam int PROD_W     = 2 * WORD_WIDTH + 1;
    localparam int NUM_W      = PROD_W + FRAC_BITS;
    localparam int QCNT_W     = $clog2(NUM_W + 1);

    typedef logic signed [WORD_WIDTH-1:0] word_t;
    typedef logic signed [PROD_W-1:0]     prod_t;

    // Saturate a wide difference symmetrically to the word range.
    function automatic word_t sat_delta(input logic signed [WORD_WIDTH:0] d);
        logic signed [WORD_WIDTH:0] dmax;
        dmax = (WORD_WIDTH+1)'((64'd1 << (WORD_WIDTH - 1)) - 64'd1);
        if (d > dmax)
            sat_delta = word_t'(dmax);
        else if (d < -dmax)
            sat_delta = word_t'(-dmax);
        else
            sat_delta = word_t'(d);
    endfunction
endpackage

// ----- rtl/ttb_div.sv -----
// Bit-serial restoring divider: one quotient bit per cycle with saturation.
module ttb_div
    import ttb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  prod_t num,
    input  prod_t den,
    output logic  busy,
    output logic  done,
    output word_t quo
);
    logic [NUM_W-1:0]  n_reg, n_next;
    logic [PROD_W:0]   r_reg, r_next;
    logic [NUM_W-1:0]  q_reg, q_next;
    logic [PROD_W-1:0] d_reg;
    logic              neg_reg;
    logic [QCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next, done_reg, done_next;
    logic [PROD_W:0]   shifted;
    logic [PROD_W-1:0] num_mag, den_mag;
    logic [WORD_WIDTH-1:0] lim, mag;

    assign num_mag = num[PROD_W-1] ? PROD_W'(-num) : PROD_W'(num);
    assign den_mag = den[PROD_W-1] ? PROD_W'(-den) : PROD_W'(den);
    assign shifted = {r_reg[PROD_W-1:0], n_reg[NUM_W-1]};

    // Step the shift-subtract loop
    always_comb
    begin
        n_next = n_reg;
        r_next = r_reg;
        q_next = q_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            n_next = {num_mag, {FRAC_BITS{1'b0}}};
            r_next = '0;
            q_next = '0;
            cnt_next = QCNT_W'(NUM_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            n_next = n_reg << 1;
            if (shifted >= {1'b0, d_reg})
            begin
                r_next = shifted - {1'b0, d_reg};
                q_next = {q_reg[NUM_W-2:0], 1'b1};
            end
            else
            begin
                r_next = shifted;
                q_next = {q_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == QCNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg <= n_next;
        r_reg <= r_next;
        q_reg <= q_next;
        if (start)
        begin
            d_reg <= den_mag;
            neg_reg <= num[PROD_W-1] ^ den[PROD_W-1];
        end
    end

    // Saturate the magnitude and apply the sign
    always_comb
    begin
        lim = neg_reg ? {1'b1, {(WORD_WIDTH-1){1'b0}}} : {1'b0, {(WORD_WIDTH-1){1'b1}}};
        if (q_reg > NUM_W'(lim))
            mag = lim;
        else
            mag = q_reg[WORD_WIDTH-1:0];
    end

    assign quo  = neg_reg ? word_t'(-mag) : word_t'(mag);
    assign busy = busy_reg;
    assign done = done_reg;
endmodule

// ----- rtl/triangle_tangent_bitangent.sv -----
// Top level: corner store, shared multiplier sequencer and divider.
//
//  channel | direction | fields
//  in      | input     | pos_x pos_y pos_z tex_u tex_v first_of_shape
//  out     | output    | tangent_x..z bitangent_x..z degenerate
//
// Corners 0 and 1 are stored on their beats. Corner 2 takes a delta step,
// the steps of one shared 32x32 multiplier (det first, then two products per
// cross term) and six passes of the bit-serial divider; the divider passes
// are skipped when the determinant is zero.
// Reset clears the corner count and the sequencer. in_ready drops while a
// triangle works and while its result waits in the output register.
module triangle_tangent_bitangent
    import ttb_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    input  word_t pos_x,
    input  word_t pos_y,
    input  word_t pos_z,
    input  word_t tex_u,
    input  word_t tex_v,
    input  logic  first_of_shape,
    output logic  out_valid,
    input  logic  out_ready,
    output word_t tangent_x,
    output word_t tangent_y,
    output word_t tangent_z,
    output word_t bitangent_x,
    output word_t bitangent_y,
    output word_t bitangent_z,
    output logic  degenerate
);
`include "triangle_tangent_bitangent_macros.svh"

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_DELTA = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_DIV   = 5'b01000,
        ST_OUT   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [1:0] cnt_reg;
    word_t p0_reg [3];
    word_t p1_reg [3];
    word_t uv0_reg [2];
    word_t uv1_reg [2];
    word_t e1_reg [3];
    word_t e2_reg [3];
    word_t du1_reg, dv1_reg, du2_reg, dv2_reg;
    prod_t det_reg, acc_reg, num_reg [6];
    word_t res_reg [6];
    logic  deg_reg;
    logic [3:0] step_reg;
    logic [2:0] didx_reg;
    word_t ma, mb;
    logic signed [2*WORD_WIDTH-1:0] mp;
    logic  div_start, div_busy, div_done;
    word_t quo;
    logic  in_fire, out_fire;
    logic [1:0] k;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_OUT);

    // Step order: det (2), then per axis tangent (2) and bitangent (2)
    assign k = step_reg < 4'd2 ? 2'd0 : 2'((step_reg - 4'd2) >> 2);
    always_comb
    begin
        ma = du1_reg;
        mb = dv2_reg;
        case (step_reg)
            4'd0: begin ma = du1_reg; mb = dv2_reg; end
            4'd1: begin ma = dv1_reg; mb = du2_reg; end
            default:
            begin
                case (step_reg[1:0])
                    2'd2: begin ma = e1_reg[k]; mb = dv2_reg; end
                    2'd3: begin ma = e2_reg[k]; mb = dv1_reg; end
                    2'd0: begin ma = e2_reg[k]; mb = du1_reg; end
                    default: begin ma = e1_reg[k]; mb = du2_reg; end
                endcase
            end
        endcase
    end
    assign mp = ma * mb;

    assign div_start = (state_reg == ST_MUL && step_reg == 4'd13 && det_reg != '0)
                    || (state_reg == ST_DIV && div_done && didx_reg != 3'd5);

    ttb_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .num(state_reg == ST_MUL ? num_reg[0] : num_reg[3'(didx_reg + 3'd1)]),
        .den(det_reg), .busy(div_busy), .done(div_done), .quo(quo)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (in_fire && !first_of_shape && cnt_reg == 2'd2) state_next = ST_DELTA;
            ST_DELTA: state_next = ST_MUL;
            ST_MUL:   if (step_reg == 4'd13) state_next = (det_reg == '0) ? ST_OUT : ST_DIV;
            ST_DIV:   if (div_done && didx_reg == 3'd5) state_next = ST_OUT;
            ST_OUT:   if (out_fire) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg <= 2'd0;
            step_reg <= '0;
            didx_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_fire)
                cnt_reg <= first_of_shape ? 2'd1 : (cnt_reg == 2'd2 ? 2'd0 : cnt_reg + 2'd1);
            if (state_reg == ST_MUL)
                step_reg <= step_reg + 4'd1;
            else
                step_reg <= '0;
            if (state_reg != ST_DIV)
                didx_reg <= '0;
            else if (div_done)
                didx_reg <= didx_reg + 3'd1;
        end
    end

    // Hold corners, deltas, products and results
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            if (first_of_shape || cnt_reg == 2'd0)
            begin
                p0_reg[0] <= pos_x; p0_reg[1] <= pos_y; p0_reg[2] <= pos_z;
                uv0_reg[0] <= tex_u; uv0_reg[1] <= tex_v;
            end
            else if (cnt_reg == 2'd1)
            begin
                p1_reg[0] <= pos_x; p1_reg[1] <= pos_y; p1_reg[2] <= pos_z;
                uv1_reg[0] <= tex_u; uv1_reg[1] <= tex_v;
            end
            else
            begin
                e2_reg[0] <= sat_delta((WORD_WIDTH+1)'(pos_x) - (WORD_WIDTH+1)'(p0_reg[0]));
                e2_reg[1] <= sat_delta((WORD_WIDTH+1)'(pos_y) - (WORD_WIDTH+1)'(p0_reg[1]));
                e2_reg[2] <= sat_delta((WORD_WIDTH+1)'(pos_z) - (WORD_WIDTH+1)'(p0_reg[2]));
                du2_reg <= sat_delta((WORD_WIDTH+1)'(tex_u) - (WORD_WIDTH+1)'(uv0_reg[0]));
                dv2_reg <= sat_delta((WORD_WIDTH+1)'(tex_v) - (WORD_WIDTH+1)'(uv0_reg[1]));
            end
        end
        if (state_reg == ST_DELTA)
        begin
            for (int i = 0; i < 3; i++)
                e1_reg[i] <= sat_delta((WORD_WIDTH+1)'(p1_reg[i]) - (WORD_WIDTH+1)'(p0_reg[i]));
            du1_reg <= sat_delta((WORD_WIDTH+1)'(uv1_reg[0]) - (WORD_WIDTH+1)'(uv0_reg[0]));
            dv1_reg <= sat_delta((WORD_WIDTH+1)'(uv1_reg[1]) - (WORD_WIDTH+1)'(uv0_reg[1]));
        end
        if (state_reg == ST_MUL)
        begin
            if (step_reg[0] == 1'b0 || step_reg == 4'd0)
                acc_reg <= PROD_W'(mp);
            if (step_reg == 4'd1)
                det_reg <= acc_reg - PROD_W'(mp);
            else if (step_reg >= 4'd3 && step_reg[0])
                num_reg[3'((step_reg - 4'd3) >> 1) == 3'd0 ? 3'd0 :
                        ((((step_reg - 4'd3) >> 1) % 2) == 0 ? 3'(((step_reg - 4'd3) >> 2))
                         : 3'(3 + ((step_reg - 4'd3) >> 2)))] <= acc_reg - PROD_W'(mp);
            deg_reg <= 1'b1;
            for (int i = 0; i < 6; i++)
                res_reg[i] <= '0;
        end
        if (state_reg == ST_DIV)
        begin
            deg_reg <= 1'b0;
            if (div_done)
                res_reg[didx_reg] <= quo;
        end
    end

    assign tangent_x   = res_reg[0];
    assign tangent_y   = res_reg[1];
    assign tangent_z   = res_reg[2];
    assign bitangent_x = res_reg[3];
    assign bitangent_y = res_reg[4];
    assign bitangent_z = res_reg[5];
    assign degenerate  = deg_reg;

    `TTB_ASSERT_IMP(a_ready_idle, in_ready, !out_valid)
    `TTB_ASSERT_IMP(a_div_quiet, state_reg == ST_IDLE, !div_busy)
    `TTB_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tangent_x))
endmodule
